// ===== design/key_press_classifier_top_defines.svh =====
// Assertion macros shared by the key press classifier RTL
`ifndef KEY_PRESS_CLASSIFIER_TOP_DEFINES_SVH
`define KEY_PRESS_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define KPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define KPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kpc_pkg.sv =====
// Types and constants of the key press classifier
`timescale 1ns / 1ps
package kpc_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned MsW    = 14;
  localparam int unsigned TickW  = 8;
  localparam int unsigned IdxW   = 3;

  typedef enum logic [1:0] {
    CODE_NONE   = 2'd0,
    CODE_SHORT  = 2'd1,
    CODE_LONG   = 2'd2,
    CODE_DOUBLE = 2'd3
  } kpc_code_e;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_READ = 1'b1
  } kpc_mode_e;

  typedef enum logic [IdxW-1:0] {
    REG_LONG_EN     = 3'd0,
    REG_DOUBLE_EN   = 3'd1,
    REG_TICK_MS     = 3'd2,
    REG_LONG_LIMIT  = 3'd3,
    REG_SHORT_LIMIT = 3'd4,
    REG_DBL_WINDOW  = 3'd5,
    REG_LONG_RELOAD = 3'd6
  } kpc_reg_e;

  localparam logic             RstLongEn     = 1'b1;
  localparam logic             RstDoubleEn   = 1'b1;
  localparam logic [TickW-1:0] RstTickMs     = 8'd20;
  localparam logic [MsW-1:0]   RstLongLimit  = 14'd1500;
  localparam logic [MsW-1:0]   RstShortLimit = 14'd200;
  localparam logic [MsW-1:0]   RstDblWindow  = 14'd200;
  localparam logic [MsW-1:0]   RstLongReload = 14'd201;

  typedef struct packed {
    logic             long_enable;
    logic             double_enable;
    logic [TickW-1:0] tick_ms;
    logic [MsW-1:0]   long_limit_ms;
    logic [MsW-1:0]   short_limit_ms;
    logic [MsW-1:0]   double_window_ms;
    logic [MsW-1:0]   long_reload_ms;
  } kpc_cfg_t;

  typedef struct packed {
    logic mode;
    logic pin_level;
  } kpc_item_t;

  typedef struct packed {
    logic [1:0] key_code;
    logic [1:0] event_code;
  } kpc_res_t;

endpackage

// ===== design/kpc_if.sv =====
// Handshake channels of the key press classifier: input items and result items
`timescale 1ns / 1ps
interface kpc_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic pin_level;

  modport source (output valid, output mode, output pin_level, input ready);
  modport sink   (input valid, input mode, input pin_level, output ready);
endinterface

interface kpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_code;
  logic [1:0] event_code;

  modport source (output valid, output key_code, output event_code, input ready);
  modport sink   (input valid, input key_code, input event_code, output ready);
endinterface

// ===== design/kpc_cfg_regs.sv =====
// Configuration register file of the key press classifier
`timescale 1ns / 1ps
module kpc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [kpc_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [kpc_pkg::MsW-1:0]  cfg_wdata_i,
  output kpc_pkg::kpc_cfg_t        cfg_o
);
  import kpc_pkg::*;

  kpc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (kpc_reg_e'(cfg_idx_i))
        REG_LONG_EN:     cfg_d.long_enable      = cfg_wdata_i[0];
        REG_DOUBLE_EN:   cfg_d.double_enable    = cfg_wdata_i[0];
        REG_TICK_MS:     cfg_d.tick_ms          = cfg_wdata_i[TickW-1:0];
        REG_LONG_LIMIT:  cfg_d.long_limit_ms    = cfg_wdata_i;
        REG_SHORT_LIMIT: cfg_d.short_limit_ms   = cfg_wdata_i;
        REG_DBL_WINDOW:  cfg_d.double_window_ms = cfg_wdata_i;
        REG_LONG_RELOAD: cfg_d.long_reload_ms   = cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_enable      <= RstLongEn;
      cfg_q.double_enable    <= RstDoubleEn;
      cfg_q.tick_ms          <= RstTickMs;
      cfg_q.long_limit_ms    <= RstLongLimit;
      cfg_q.short_limit_ms   <= RstShortLimit;
      cfg_q.double_window_ms <= RstDblWindow;
      cfg_q.long_reload_ms   <= RstLongReload;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/kpc_core.sv =====
// Button state, hold and gap timers, and the per-item classification step
`timescale 1ns / 1ps
`include "key_press_classifier_top_defines.svh"
module kpc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  kpc_pkg::kpc_item_t  item_i,
  input  kpc_pkg::kpc_cfg_t   cfg_i,
  output kpc_pkg::kpc_res_t   res_o
);
  import kpc_pkg::*;

  logic              cur_q, cur_d, prev_q, prev_d;
  logic [TimerW-1:0] hold_q, hold_d, gap_q, gap_d;
  logic              frs_q, frs_d;
  logic [1:0]        latch_q, latch_d;
  logic [1:0]        ev;

  logic              prev, cur;
  logic [TimerW-1:0] h_edge, h_add, g_rel, g_add;
  logic [TimerW-1:0] long_lim, short_lim, win, tick, reload;
  logic              long_fire, rel_short, frs_rel;

  assign long_lim  = TimerW'(cfg_i.long_limit_ms);
  assign short_lim = TimerW'(cfg_i.short_limit_ms);
  assign win       = TimerW'(cfg_i.double_window_ms);
  assign tick      = TimerW'(cfg_i.tick_ms);
  assign reload    = TimerW'(cfg_i.long_reload_ms);

  always_comb begin
    cur_d   = cur_q;
    prev_d  = prev_q;
    hold_d  = hold_q;
    gap_d   = gap_q;
    frs_d   = frs_q;
    latch_d = latch_q;
    ev      = CODE_NONE;
    res_o   = '0;

    prev = cur_q;
    cur  = ~item_i.pin_level;

    // hold timer: clear on press, count while held at or below the limit
    h_edge = (!prev && cur && cfg_i.long_enable) ? '0 : hold_q;
    h_add  = (prev && cur && cfg_i.long_enable && (h_edge <= long_lim))
             ? h_edge + tick : h_edge;
    long_fire = prev && cfg_i.long_enable && (h_add > long_lim);
    if (long_fire) begin
      ev     = CODE_LONG;
      hold_d = reload;
    end else begin
      hold_d = h_add;
    end

    // release within the short limit
    rel_short = prev && !cur && (hold_d <= short_lim);
    frs_rel   = frs_q;
    g_rel     = gap_q;
    if (rel_short) begin
      if (!cfg_i.double_enable) begin
        ev = CODE_SHORT;
      end else if (!frs_q) begin
        frs_rel = 1'b1;
        g_rel   = '0;
      end else if (gap_q <= win) begin
        ev      = CODE_DOUBLE;
        frs_rel = 1'b0;
      end
    end

    // gap timer runs while a first release is pending; timeout is a short press
    g_add = frs_rel ? g_rel + tick : g_rel;
    gap_d = g_add;
    frs_d = frs_rel;
    if (frs_rel && (g_add > win)) begin
      ev    = CODE_SHORT;
      frs_d = 1'b0;
    end

    if (item_i.mode == MODE_READ) begin
      res_o.key_code = latch_q;
      if (step_i) begin
        latch_d = CODE_NONE;
      end
    end else begin
      res_o.event_code = ev;
      if (step_i) begin
        prev_d = prev;
        cur_d  = cur;
        if (ev != CODE_NONE) begin
          latch_d = ev;
        end
      end else begin
        hold_d = hold_q;
        gap_d  = gap_q;
        frs_d  = frs_q;
      end
    end
    if (!step_i || item_i.mode == MODE_READ) begin
      hold_d = hold_q;
      gap_d  = gap_q;
      frs_d  = frs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= 1'b0;
      prev_q  <= 1'b0;
      hold_q  <= '0;
      gap_q   <= '0;
      frs_q   <= 1'b0;
      latch_q <= CODE_NONE;
    end else begin
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      hold_q  <= hold_d;
      gap_q   <= gap_d;
      frs_q   <= frs_d;
      latch_q <= latch_d;
    end
  end

  `KPC_ASSERT_NXT(a_read_clears, step_i && item_i.mode == MODE_READ, latch_q == CODE_NONE, "read did not clear latched code")
  `KPC_ASSERT_NXT(a_event_latched, step_i && item_i.mode == MODE_TICK && ev != CODE_NONE, latch_q == $past(ev), "event not latched")
  `KPC_ASSERT_NXT(a_idle_holds, !step_i, $stable(hold_q) && $stable(gap_q) && $stable(latch_q), "state moved without an item")

endmodule

// ===== design/key_press_classifier_top.sv =====
// Top level of the key press classifier: channel registers, config and core
`timescale 1ns / 1ps
`include "key_press_classifier_top_defines.svh"
// Short / long / double press classifier for one active-low push button.
// Input channel (in_i): mode 0 is a sampling tick carrying the raw pin
//   level (0 = pressed); mode 1 reads the latched code and clears it.
// Output channel (out_o): one result item per input item. A tick gives the
//   code it caused in event_code (key_code 0); a read gives the latched code
//   in key_code (event_code 0). Codes: 0 none, 1 short, 2 long, 3 double.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
//   clock edge; index 7 is ignored. Write only while the block is idle.
// Flow: an accepted item is held in the input register, then stepped into the
//   result register. Throughput: one item per cycle while out_o is ready; the
//   step is one pass of compares and 16-bit adds between the two registers.
// Reset (rst_ni low, asynchronous): config returns to its defaults
//   (long and double on, 20 ms tick, limits 1500/200/200, reload 201),
//   timers and history clear, latched code is none, both channels empty.
// Stall: while a result waits for out_o.ready, one more item is taken into
//   the input register; after that in_i.ready drops until the result leaves.
module key_press_classifier_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  kpc_in_if.sink                   in_i,
  kpc_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [kpc_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [kpc_pkg::MsW-1:0]  cfg_wdata_i
);
  import kpc_pkg::*;

  kpc_cfg_t  cfg;
  kpc_item_t item_q, item_d;
  kpc_res_t  res, res_q, res_d;
  logic      in_vld_q, in_vld_d, out_vld_q, out_vld_d;
  logic      step, in_take;

  kpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // step retires the item in the input register into the result register
  assign step     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step;
  assign in_take  = in_i.valid && in_i.ready;

  kpc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    item_d    = item_q;
    in_vld_d  = in_vld_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    if (in_take) begin
      item_d.mode      = in_i.mode;
      item_d.pin_level = in_i.pin_level;
      in_vld_d         = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    if (step) begin
      res_d     = res;
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.key_code   = res_q.key_code;
  assign out_o.event_code = res_q.event_code;

  `KPC_ASSERT_IMP(a_one_field, out_vld_q, res_q.key_code == CODE_NONE || res_q.event_code == CODE_NONE, "both result fields nonzero")
  `KPC_ASSERT_IMP(a_stall_cause, !in_i.ready, in_vld_q && out_vld_q && !out_o.ready, "input stalled without a waiting result")
  `KPC_ASSERT_NXT(a_step_fills, step, out_vld_q, "retired item left no result")

endmodule
